// File: design/sdat_pkg.sv
// ----------------------------------------------------------------------------
// sdat_pkg: shared types and constants for the seen-device aging table
// Table size, field widths, result codes and controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none
package sdat_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);

   localparam int ADDR_W     = 48;
   localparam int RSSI_W     = 8;
   localparam int FRESH_W    = 8;
   localparam int STATUS_W   = 3;
   localparam int SLOT_W     = 4;
   localparam int DEVCNT_W   = 5;
   localparam int ENTRY_W    = ADDR_W + RSSI_W + FRESH_W;

   localparam logic [FRESH_W-1:0] RELOAD_RESET = 8'd16;

   localparam logic [STATUS_W-1:0] ST_REFRESHED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_SCAN_HIT  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_SCAN_MISS = 3'd4;

   localparam logic MODE_ADV  = 1'b0;
   localparam logic MODE_SCAN = 1'b1;

   typedef struct packed {
      logic [ADDR_W-1:0]  address;
      logic [RSSI_W-1:0]  strength;
      logic [FRESH_W-1:0] freshness;
   } entry_type;

   typedef struct packed {
      logic load;     // capture the accepted item, reset walk pointers
      logic read;     // issue table read at the read pointer
      logic eval;     // examine the entry just read
      logic finish;   // append / build result
   } cmd_type;

   typedef struct packed {
      logic walk_end; // read pointer reached entry count
      logic out_free; // result register can take a new item
   } stat_type;

endpackage
`default_nettype wire

// File: design/sdat_ram.sv
// ----------------------------------------------------------------------------
// sdat_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module sdat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: design/sdat_ctrl.sv
// ----------------------------------------------------------------------------
// sdat_ctrl: sequencer for the table walk
// Steps read / evaluate per entry, then waits for output room and finishes.
// ----------------------------------------------------------------------------
`default_nettype none
module sdat_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire sdat_pkg::stat_type stat,
   output sdat_pkg::cmd_type      cmd
);
   import sdat_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RD   = 2'd1;
   localparam logic [1:0] S_EV   = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_RD;
            end
         end
         S_RD: begin
            if (stat.walk_end) begin
               state_in = S_FIN;
            end else begin
               cmd.read = 1'b1;
               state_in = S_EV;
            end
         end
         S_EV: begin
            cmd.eval = 1'b1;
            state_in = S_RD;
         end
         S_FIN: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// File: design/sdat_datapath.sv
// ----------------------------------------------------------------------------
// sdat_datapath: table storage, walk pointers and result register
// Compacts the table in place with separate read and write pointers.
// ----------------------------------------------------------------------------
`default_nettype none
module sdat_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire sdat_pkg::cmd_type              cmd,
   output sdat_pkg::stat_type                  stat,
   input  wire logic                           req_mode,
   input  wire logic [sdat_pkg::ADDR_W-1:0]    req_address,
   input  wire logic signed [sdat_pkg::RSSI_W-1:0] req_rssi,
   input  wire logic                           csr_wr_en,
   input  wire logic [sdat_pkg::FRESH_W-1:0]   csr_wr_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [sdat_pkg::STATUS_W-1:0]       rsp_status,
   output logic [sdat_pkg::SLOT_W-1:0]         rsp_slot,
   output logic [sdat_pkg::DEVCNT_W-1:0]       rsp_device_count,
   output logic signed [sdat_pkg::RSSI_W-1:0]  rsp_entry_rssi
);
   import sdat_pkg::*;

   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

   logic [FRESH_W-1:0] reload_ff;
   logic               mode_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic [RSSI_W-1:0]  rssi_ff;
   logic [CNT_W-1:0]   count_ff, rptr_ff, wptr_ff;
   logic               known_ff;
   logic [CNT_W-1:0]   slot_ff;
   logic [RSSI_W-1:0]  found_ff;

   logic                   rsp_valid_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [SLOT_W-1:0]      rsp_slot_ff;
   logic [DEVCNT_W-1:0]    rsp_count_ff;
   logic [RSSI_W-1:0]      rsp_rssi_ff;

   entry_type          rd_entry, wr_entry;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic               hit, drop;

   sdat_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (cmd.read),
      .rd_addr (rptr_ff[IDX_W-1:0]),
      .rd_data (rd_entry)
   );

   assign hit  = (rd_entry.address == addr_ff);
   assign drop = !hit && (rd_entry.freshness == '0);

   // table write: in advertising mode, write back kept entries at the write pointer during walk, append at finish
   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = wptr_ff[IDX_W-1:0];
      wr_entry = rd_entry;
      if (cmd.eval && mode_ff == MODE_ADV && !drop) begin
         wr_en = 1'b1;
         wr_entry.freshness = hit ? reload_ff : rd_entry.freshness - 1'b1;
      end else if (cmd.finish && mode_ff == MODE_ADV && !known_ff && wptr_ff < FULL_CNT) begin
         wr_en    = 1'b1;
         wr_entry = '{address: addr_ff, strength: rssi_ff, freshness: reload_ff};
      end
   end

   assign stat.walk_end = (rptr_ff == count_ff);
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff    <= RELOAD_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            reload_ff <= csr_wr_data;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
            if (mode_ff == MODE_ADV) begin
               if (!known_ff && wptr_ff < FULL_CNT) begin
                  count_ff <= wptr_ff + 1'b1;
               end else begin
                  count_ff <= wptr_ff;
               end
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_mode;
         addr_ff  <= req_address;
         rssi_ff  <= req_rssi;
         rptr_ff  <= '0;
         wptr_ff  <= '0;
         known_ff <= 1'b0;
         slot_ff  <= '0;
         found_ff <= '0;
      end
      if (cmd.eval) begin
         rptr_ff <= rptr_ff + 1'b1;
         if (mode_ff == MODE_ADV) begin
            if (!drop) begin
               wptr_ff <= wptr_ff + 1'b1;
            end
            if (hit && !known_ff) begin
               known_ff <= 1'b1;
               slot_ff  <= wptr_ff;
               found_ff <= rd_entry.strength;
            end
         end else if (hit && !known_ff) begin
            known_ff <= 1'b1;
            slot_ff  <= rptr_ff;
            found_ff <= rd_entry.strength;
         end
      end
      if (cmd.finish) begin
         if (mode_ff == MODE_SCAN) begin
            rsp_status_ff <= known_ff ? ST_SCAN_HIT : ST_SCAN_MISS;
            rsp_slot_ff   <= SLOT_W'(slot_ff);
            rsp_rssi_ff   <= found_ff;
            rsp_count_ff  <= DEVCNT_W'(count_ff);
         end else if (known_ff) begin
            rsp_status_ff <= ST_REFRESHED;
            rsp_slot_ff   <= SLOT_W'(slot_ff);
            rsp_rssi_ff   <= found_ff;
            rsp_count_ff  <= DEVCNT_W'(wptr_ff);
         end else if (wptr_ff < FULL_CNT) begin
            rsp_status_ff <= ST_ADDED;
            rsp_slot_ff   <= SLOT_W'(wptr_ff);
            rsp_rssi_ff   <= rssi_ff;
            rsp_count_ff  <= DEVCNT_W'(wptr_ff + 1'b1);
         end else begin
            rsp_status_ff <= ST_FULL;
            rsp_slot_ff   <= '0;
            rsp_rssi_ff   <= '0;
            rsp_count_ff  <= DEVCNT_W'(wptr_ff);
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_device_count = rsp_count_ff;
   assign rsp_entry_rssi   = rsp_rssi_ff;

endmodule
`default_nettype wire

// File: design/seen_device_aging_table_top.sv
// ----------------------------------------------------------------------------
// seen_device_aging_table_top: seen-device table with freshness aging
// Looks up, refreshes, ages out and appends 48-bit device addresses.
// ----------------------------------------------------------------------------
// Timing: after an accept the sequencer walks the n entries held at accept,
//   each with a table RAM read, then evaluate/write back; it then waits for
//   the result register to be free and posts the result. One item is held at
//   a time: the next is taken only once the walk is done and the result posted.
// Reset (synchronous): table empty, freshness reload 16, no result pending.
//   Table RAM contents are not cleared; only entries below the count are read.
`default_nettype none
module seen_device_aging_table_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_mode,
   input  wire logic [sdat_pkg::ADDR_W-1:0]        req_address,
   input  wire logic signed [sdat_pkg::RSSI_W-1:0] req_rssi,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [sdat_pkg::STATUS_W-1:0]           rsp_status,
   output logic [sdat_pkg::SLOT_W-1:0]             rsp_slot,
   output logic [sdat_pkg::DEVCNT_W-1:0]           rsp_device_count,
   output logic signed [sdat_pkg::RSSI_W-1:0]      rsp_entry_rssi,
   input  wire logic                               csr_wr_en,
   input  wire logic [sdat_pkg::FRESH_W-1:0]       csr_wr_data
);
   import sdat_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Sequencer: accepts one item at a time, walks the table, then posts
   // the result once the output register is free.
   sdat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: table RAM, read/write pointers (write pointer lags when an
   // aged-out entry is dropped, which closes the gap in order), result reg.
   sdat_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_mode         (req_mode),
      .req_address      (req_address),
      .req_rssi         (req_rssi),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_slot         (rsp_slot),
      .rsp_device_count (rsp_device_count),
      .rsp_entry_rssi   (rsp_entry_rssi)
   );

   // one item in flight: the input closes right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input open right after accept");

   // count never exceeds the table
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_device_count <= DEVCNT_W'(TABLE_ENTRIES))
      else $error("device count above table size");

   // an added entry sits at the tail
   a_added_tail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_ADDED |->
         rsp_slot == SLOT_W'(rsp_device_count - 1'b1))
      else $error("added entry not at tail");

   // miss and full carry no slot or strength
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_SCAN_MISS || rsp_status == ST_FULL) |->
         rsp_slot == '0 && rsp_entry_rssi == '0)
      else $error("miss/full result carries data");

endmodule
`default_nettype wire

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for seen_device_aging_table_top
// Directed table of events, then random advertising and scan events from a
// small address pool (some fully random), checked in order against a behavioral table model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
   import sdat_pkg::*;

   localparam int N_RANDOM = 1930;
   localparam int MAX_SHOW = 10;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [DEVCNT_W-1:0] count;
      logic [RSSI_W-1:0]   rssi;
   } rsp_type;

   typedef struct {
      logic              mode;
      logic [ADDR_W-1:0] addr;
      logic [RSSI_W-1:0] rssi;
      logic              has_exp;  // typed-in expectation present
      rsp_type           exp;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_mode = 1'b0;
   logic [ADDR_W-1:0] req_address = '0;
   logic signed [RSSI_W-1:0] req_rssi = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0] rsp_slot;
   logic [DEVCNT_W-1:0] rsp_device_count;
   logic signed [RSSI_W-1:0] rsp_entry_rssi;
   logic csr_wr_en = 1'b0;
   logic [FRESH_W-1:0] csr_wr_data = '0;

   seen_device_aging_table_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_address(req_address), .req_rssi(req_rssi),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_slot(rsp_slot), .rsp_device_count(rsp_device_count),
      .rsp_entry_rssi(rsp_entry_rssi),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---- model of the device table ----
   logic [ADDR_W-1:0]  tbl_addr  [TABLE_ENTRIES];
   logic [RSSI_W-1:0]  tbl_rssi  [TABLE_ENTRIES];
   logic [FRESH_W-1:0] tbl_fresh [TABLE_ENTRIES];
   int                 tbl_count = 0;
   logic [FRESH_W-1:0] reload = RELOAD_RESET;

   rsp_type pending_rsp[$];
   int   n_err = 0;
   int   n_checked = 0;
   int   n_full = 0, n_hit = 0, n_miss = 0, n_added = 0, n_refresh = 0;

   // hold-off requested by the stimulus process; counted down by receiver
   int   hold_cycles = 0;
   // receiver wait left before the next item
   int   rx_wait = 0;

   function automatic rsp_type table_event(input logic mode, input logic [ADDR_W-1:0] a,
                                           input logic [RSSI_W-1:0] r);
      rsp_type o;
      bit known;
      int i;
      o = '0;
      known = 0;
      if (mode == MODE_SCAN) begin
         o.status = ST_SCAN_MISS;
         for (i = 0; i < tbl_count; i++) begin
            if (tbl_addr[i] == a) begin
               o.status = ST_SCAN_HIT;
               o.slot = i[SLOT_W-1:0];
               o.rssi = tbl_rssi[i];
               break;
            end
         end
      end else begin
         i = 0;
         while (i < tbl_count) begin
            if (tbl_addr[i] == a) begin
               tbl_fresh[i] = reload;
               if (!known) begin
                  known = 1;
                  o.slot = i[SLOT_W-1:0];
                  o.rssi = tbl_rssi[i];
               end
               i++;
            end else if (tbl_fresh[i] == 0) begin
               // aged out: later entries close the gap, same index examined next
               for (int k = i; k + 1 < tbl_count; k++) begin
                  tbl_addr[k]  = tbl_addr[k+1];
                  tbl_rssi[k]  = tbl_rssi[k+1];
                  tbl_fresh[k] = tbl_fresh[k+1];
               end
               tbl_count--;
            end else begin
               tbl_fresh[i] = tbl_fresh[i] - 1;
               i++;
            end
         end
         if (known) o.status = ST_REFRESHED;
         else if (tbl_count < TABLE_ENTRIES) begin
            tbl_addr[tbl_count]  = a;
            tbl_rssi[tbl_count]  = r;
            tbl_fresh[tbl_count] = reload;
            o.slot = tbl_count[SLOT_W-1:0];
            o.rssi = r;
            tbl_count++;
            o.status = ST_ADDED;
         end else o.status = ST_FULL;
      end
      o.count = tbl_count[DEVCNT_W-1:0];
      return o;
   endfunction

   // ---- stimulus ----
   // valid stays up after an accept; the next call either drops it or
   // presents the next item in the same step, and drain() drops it
   task automatic send_event(input logic mode, input logic [ADDR_W-1:0] a,
                             input logic [RSSI_W-1:0] r, input bit use_exp,
                             input rsp_type typed, input bit no_gap);
      rsp_type p;
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_address <= a;
      req_rssi    <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // accepted at this edge
      p = table_event(mode, a, r);
      if (use_exp && p !== typed) begin
         n_err++;
         if (n_err <= MAX_SHOW)
            $display("table mismatch at directed row: typed %h model %h", typed, p);
      end
      pending_rsp.push_back(p);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reload(input logic [FRESH_W-1:0] v);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      reload = v;
   endtask

   function automatic logic [ADDR_W-1:0] pool_addr(input int k);
      // small pool with extreme neighbours so matches and aging happen often
      case (k % 24)
         0: return '0;
         1: return '1;
         2: return 48'h8000_0000_0000;
         3: return 48'h0000_0000_0001;
         default: return {32'hA5C3_0F1E, 16'(k % 24)};
      endcase
   endfunction

   function automatic rsp_type mk(input logic [STATUS_W-1:0] s, input int sl, input int c,
                                  input logic [RSSI_W-1:0] r);
      rsp_type o;
      o.status = s; o.slot = sl[SLOT_W-1:0]; o.count = c[DEVCNT_W-1:0]; o.rssi = r;
      return o;
   endfunction

   row_type dir_rows[$];

   initial begin
      rsp_type none;
      int b, addr_span;
      logic [ADDR_W-1:0] ra;
      none = '0;
      // after reset: scan miss on empty table, then add extremes
      dir_rows.push_back('{MODE_SCAN, 48'h0, 8'h00, 1, mk(ST_SCAN_MISS, 0, 0, 8'h00)});
      dir_rows.push_back('{MODE_ADV, 48'h0, 8'h80, 1, mk(ST_ADDED, 0, 1, 8'h80)});
      dir_rows.push_back('{MODE_ADV, '1, 8'h7F, 1, mk(ST_ADDED, 1, 2, 8'h7F)});
      dir_rows.push_back('{MODE_SCAN, '1, 8'h00, 1, mk(ST_SCAN_HIT, 1, 2, 8'h7F)});
      // refreshed entry keeps old strength
      dir_rows.push_back('{MODE_ADV, 48'h0, 8'h11, 1, mk(ST_REFRESHED, 0, 2, 8'h80)});
      dir_rows.push_back('{MODE_SCAN, 48'h5555_AAAA_5555, 8'hFF, 1,
                           mk(ST_SCAN_MISS, 0, 2, 8'h00)});
      // fill the table, then table full
      for (int k = 0; k < 15; k++)
         dir_rows.push_back('{MODE_ADV, 48'h1000 + k, 8'(k * 17), 0, none});

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i])
         send_event(dir_rows[i].mode, dir_rows[i].addr, dir_rows[i].rssi,
                    dir_rows[i].has_exp, dir_rows[i].exp, 0);

      // reload 0: refreshed entries are left at zero freshness; a match is refreshed, not removed
      write_reload(8'd0);
      send_event(MODE_ADV, 48'h1005, 8'h01, 0, none, 0);
      send_event(MODE_ADV, 48'h1005, 8'h02, 0, none, 0);
      send_event(MODE_SCAN, 48'h1005, 8'h03, 0, none, 0);

      // long receiver hold-off while the sender keeps offering
      write_reload(8'd255);
      hold_cycles = 300;
      for (int k = 0; k < 6; k++)
         send_event(MODE_ADV, 48'h2000 + k, 8'h40, 0, none, 1);

      // random phases over several reload settings; a sender pause each phase
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: write_reload(8'd16);
            1: write_reload(8'd0);
            2: write_reload(8'd255);
            3: write_reload(8'd1);
            default: write_reload(8'($urandom_range(0, 40)));
         endcase
         addr_span = (ph % 2) ? 24 : 12;
         for (int n = 0; n < N_RANDOM / 6; n++) begin
            b = $urandom_range(0, 99);
            if (b < 85) ra = pool_addr($urandom_range(0, addr_span - 1));
            else ra = ADDR_W'({$urandom, $urandom});
            send_event(($urandom_range(0, 3) == 0) ? MODE_SCAN : MODE_ADV, ra,
                       8'($urandom), 0, none, 0);
            if (n == 100) drain();  // sender waits until all results came
         end
      end

      drain();
      $display("covered %0d events: %0d added, %0d refreshed, %0d full,",
               n_checked, n_added, n_refresh, n_full);
      $display("  %0d scan hit, %0d miss; reload swept over 0, 1, 16, 255 and random",
               n_hit, n_miss);
      if (n_err == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // ---- receiver: random wait per item, long hold-off on request ----
   always @(posedge clock) begin
      int w;
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall   <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
         w = $urandom_range(0, 3);
         rx_wait   <= w;
         rsp_stall <= (w != 0);
      end else if (rx_wait > 0) begin
         rx_wait   <= rx_wait - 1;
         rsp_stall <= (rx_wait > 1);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---- checker ----
   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_status, rsp_slot, rsp_device_count, rsp_entry_rssi};
         if (pending_rsp.size() == 0) begin
            n_err++;
            if (n_err <= MAX_SHOW) $display("unexpected item: got %h", got);
         end else begin
            want = pending_rsp.pop_front();
            n_checked++;
            case (want.status)
               ST_ADDED:     n_added++;
               ST_REFRESHED: n_refresh++;
               ST_FULL:      n_full++;
               ST_SCAN_HIT:  n_hit++;
               default:      n_miss++;
            endcase
            if (got !== want) begin
               n_err++;
               if (n_err <= MAX_SHOW)
                  $display("mismatch: status %0d/%0d slot %0d/%0d count %0d/%0d %s",
                           want.status, got.status, want.slot, got.slot,
                           want.count, got.count,
                           $sformatf("rssi %0d/%0d", $signed(want.rssi),
                                     $signed(got.rssi)));
            end
         end
      end
   end

   // ---- run limit ----
   initial begin
      #4_000_000;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule
